/* design/mfcrc_pkg.sv */
// Shared types, constants, CRC step and CRC-extra table for the frame CRC unit.
package mfcrc_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam int          POS_W        = 3;
    localparam logic [2:0]  POS_IDLE     = 3'd0;
    localparam logic [2:0]  POS_ID       = 3'd5;
    localparam logic [2:0]  POS_SAT      = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] crc_value;
        logic [7:0]  extra_seed;
    } out_item_t;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic       restart;
        logic       capture_id;
        logic       last;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

    function automatic logic [7:0] extra_lookup(input logic [7:0] id);
        logic [7:0] v;
        unique case (id)
            8'd0:   v = 8'd72;
            8'd1:   v = 8'd39;
            8'd2:   v = 8'd190;
            8'd3:   v = 8'd92;
            8'd4:   v = 8'd191;
            8'd5:   v = 8'd217;
            8'd6:   v = 8'd104;
            8'd7:   v = 8'd119;
            8'd9:   v = 8'd219;
            8'd10:  v = 8'd60;
            8'd11:  v = 8'd186;
            8'd12:  v = 8'd10;
            8'd20:  v = 8'd89;
            8'd21:  v = 8'd159;
            8'd22:  v = 8'd162;
            8'd23:  v = 8'd121;
            8'd25:  v = 8'd149;
            8'd26:  v = 8'd222;
            8'd27:  v = 8'd110;
            8'd28:  v = 8'd179;
            8'd29:  v = 8'd136;
            8'd30:  v = 8'd66;
            8'd31:  v = 8'd126;
            8'd32:  v = 8'd185;
            8'd33:  v = 8'd147;
            8'd34:  v = 8'd112;
            8'd35:  v = 8'd252;
            8'd36:  v = 8'd162;
            8'd37:  v = 8'd215;
            8'd38:  v = 8'd229;
            8'd39:  v = 8'd128;
            8'd40:  v = 8'd9;
            8'd41:  v = 8'd106;
            8'd42:  v = 8'd101;
            8'd43:  v = 8'd213;
            8'd44:  v = 8'd4;
            8'd45:  v = 8'd229;
            8'd46:  v = 8'd21;
            8'd47:  v = 8'd214;
            8'd48:  v = 8'd215;
            8'd49:  v = 8'd14;
            8'd50:  v = 8'd206;
            8'd51:  v = 8'd50;
            8'd52:  v = 8'd157;
            8'd53:  v = 8'd126;
            8'd54:  v = 8'd108;
            8'd55:  v = 8'd213;
            8'd56:  v = 8'd95;
            8'd57:  v = 8'd5;
            8'd58:  v = 8'd127;
            8'd62:  v = 8'd57;
            8'd63:  v = 8'd126;
            8'd64:  v = 8'd130;
            8'd65:  v = 8'd119;
            8'd66:  v = 8'd193;
            8'd67:  v = 8'd191;
            8'd68:  v = 8'd236;
            8'd69:  v = 8'd158;
            8'd70:  v = 8'd143;
            8'd73:  v = 8'd104;
            8'd74:  v = 8'd123;
            8'd75:  v = 8'd131;
            8'd76:  v = 8'd8;
            8'd100: v = 8'd174;
            8'd140: v = 8'd155;
            8'd150: v = 8'd143;
            8'd151: v = 8'd29;
            8'd152: v = 8'd208;
            8'd153: v = 8'd188;
            8'd154: v = 8'd118;
            8'd155: v = 8'd242;
            8'd156: v = 8'd19;
            8'd157: v = 8'd97;
            8'd158: v = 8'd233;
            8'd251: v = 8'd178;
            8'd252: v = 8'd224;
            8'd253: v = 8'd60;
            8'd254: v = 8'd106;
            8'd255: v = 8'd7;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/mavlink_frame_crc_unit.sv */
// Frame CRC unit: byte front end, classified-byte queue, CRC back end.
// Throughput: one byte per cycle, sustained, while results are taken.
// Result path: a frame's last byte passes through the queue, then the output register;
// it waits in the queue while an earlier result is still not taken.
// The queue depth sets how many bytes can be taken while the result waits.
// Reset: asynchronous, active low; CRC to 0xFFFF, id and position to zero.
module mavlink_frame_crc_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  mfcrc_pkg::in_item_t  byte_item,
    output logic                 crc_valid,
    input  logic                 crc_ready,
    output mfcrc_pkg::out_item_t crc_item
);

    mfcrc_pkg::q_status_t q_status;
    mfcrc_pkg::op_t       push_op;
    mfcrc_pkg::op_t       pop_op;
    logic                 push;
    logic                 pop;

    mfcrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_op    (push_op)
    );

    mfcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .pop_op   (pop_op),
        .q_status (q_status)
    );

    mfcrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_op    (pop_op),
        .pop       (pop),
        .crc_valid (crc_valid),
        .crc_ready (crc_ready),
        .crc_item  (crc_item)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> q_status.full)
        else $error("input stalled with room in queue");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(crc_valid) |-> $past(pop && pop_op.last))
        else $error("result without a frame end");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_op.last) |-> (!crc_valid || crc_ready))
        else $error("frame end overwrote a pending result");

endmodule

/* design/mfcrc_front.sv */
// Front end: accepts frame bytes and classifies them by frame position.
module mfcrc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  mfcrc_pkg::in_item_t  byte_item,
    input  mfcrc_pkg::q_status_t q_status,
    output logic                 push,
    output mfcrc_pkg::op_t       push_op
);

    logic [mfcrc_pkg::POS_W-1:0] pos_reg;
    logic [mfcrc_pkg::POS_W-1:0] pos_next;
    logic                        restart;

    assign byte_ready = !q_status.full;
    assign push       = byte_valid && byte_ready;
    assign restart    = byte_item.frame_start || (pos_reg == mfcrc_pkg::POS_IDLE);

    always_comb
    begin
        push_op.restart    = restart;
        push_op.capture_id = !restart && (pos_reg == mfcrc_pkg::POS_ID);
        push_op.last       = byte_item.frame_end;
        push_op.data       = byte_item.data_byte;
    end

    // Only position 5 matters, so the counter saturates just past it.
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            priority if (byte_item.frame_end)
                pos_next = mfcrc_pkg::POS_IDLE;
            else if (restart)
                pos_next = mfcrc_pkg::POS_W'(1);
            else if (pos_reg != mfcrc_pkg::POS_SAT)
                pos_next = pos_reg + mfcrc_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= mfcrc_pkg::POS_IDLE;
        else
            pos_reg <= pos_next;
    end

endmodule

/* design/mfcrc_queue.sv */
// Short FIFO of classified bytes between the front and the back.
module mfcrc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mfcrc_pkg::op_t       push_op,
    input  logic                 pop,
    output mfcrc_pkg::op_t       pop_op,
    output mfcrc_pkg::q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    mfcrc_pkg::op_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_op         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/mfcrc_back.sv */
// Back end: runs the CRC, captures the message id and registers the result.
module mfcrc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mfcrc_pkg::q_status_t q_status,
    input  mfcrc_pkg::op_t       pop_op,
    output logic                 pop,
    output logic                 crc_valid,
    input  logic                 crc_ready,
    output mfcrc_pkg::out_item_t crc_item
);

    logic [15:0]          crc_reg;
    logic [15:0]          crc_next;
    logic [7:0]           id_reg;
    logic [7:0]           id_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mfcrc_pkg::out_item_t out_reg;
    mfcrc_pkg::out_item_t out_next;
    logic [15:0]          crc_step;
    logic [7:0]           id_step;
    logic [7:0]           extra;

    assign crc_valid = out_valid_reg;
    assign crc_item  = out_reg;

    // Bytes that end no frame drain even while a result waits.
    assign pop = !q_status.empty && (!pop_op.last || !out_valid_reg || crc_ready);

    always_comb
    begin
        crc_step = pop_op.restart ? mfcrc_pkg::CRC_INIT
                                  : mfcrc_pkg::crc_fold(crc_reg, pop_op.data);
        priority if (pop_op.restart)
            id_step = 8'h00;
        else if (pop_op.capture_id)
            id_step = pop_op.data;
        else
            id_step = id_reg;
        extra = mfcrc_pkg::extra_lookup(id_step);

        crc_next       = crc_reg;
        id_next        = id_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !crc_ready;
        if (pop)
        begin
            if (pop_op.last)
            begin
                out_next.crc_value  = mfcrc_pkg::crc_fold(crc_step, extra);
                out_next.extra_seed = extra;
                out_valid_next      = 1'b1;
                crc_next            = mfcrc_pkg::CRC_INIT;
                id_next             = 8'h00;
            end
            else
            begin
                crc_next = crc_step;
                id_next  = id_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= mfcrc_pkg::CRC_INIT;
            id_reg        <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            id_reg        <= id_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* test/mavlink_frame_crc_unit_tb.sv */
// Self-checking testbench for the frame CRC unit: directed table, then random frames.
module mavlink_frame_crc_unit_tb;

    localparam int          DIR_ROWS     = 28;
    localparam int          RANDOM_BYTES = 1550;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [8:0]  ID_POS       = 9'd5;
    localparam logic [8:0]  POS_LIMIT    = 9'd511;
    localparam logic [7:0]  SYNC_BYTE    = 8'hFE;

    typedef struct {
        mfcrc_pkg::in_item_t  stim;
        bit                   typed;
        mfcrc_pkg::out_item_t want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 byte_valid;
    logic                 byte_ready;
    mfcrc_pkg::in_item_t  byte_item;
    logic                 crc_valid;
    logic                 crc_ready;
    mfcrc_pkg::out_item_t crc_item;

    // Predictor state
    logic [15:0] frame_crc;
    logic [8:0]  frame_pos;
    logic [7:0]  frame_id;
    logic [7:0]  id_extra [256];

    mfcrc_pkg::out_item_t crc_expect [$];
    bit                   calm;
    int                   errors;
    int                   bytes_sent;
    int                   checks_done;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // frame that ends on its start byte: only the extra byte is folded
        '{'{8'hFE, 1'b1, 1'b1}, 1'b1, '{16'hC1CB, 8'd72}},
        // byte with no start flag while idle acts as the start byte
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{16'hC1CB, 8'd72}},
        // id 255, start flag on a byte other than the sync value
        '{'{8'hFF, 1'b1, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'hFF, 1'b0, 1'b1}, 1'b0, '{16'h0, 8'h0}},
        // id 0 with one payload byte
        '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'hAA, 1'b0, 1'b1}, 1'b0, '{16'h0, 8'h0}},
        // early end before the id byte
        '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h09, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h12, 1'b0, 1'b1}, 1'b0, '{16'h0, 8'h0}},
        // restart in the middle of a frame, then an early end
        '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h04, 1'b0, 1'b1}, 1'b0, '{16'h0, 8'h0}},
        // missing start flag, id with no table entry
        '{'{8'h80, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h01, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h02, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h03, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h04, 1'b0, 1'b0}, 1'b0, '{16'h0, 8'h0}},
        '{'{8'h08, 1'b0, 1'b1}, 1'b0, '{16'h0, 8'h0}}
    };

    mavlink_frame_crc_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .crc_valid  (crc_valid),
        .crc_ready  (crc_ready),
        .crc_item   (crc_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // CRC-extra table, indexed by message id; unlisted ids are zero
    initial
    begin
        foreach (id_extra[i])
            id_extra[i] = 8'd0;
        id_extra[0]   = 72;  id_extra[1]   = 39;  id_extra[2]   = 190; id_extra[3]   = 92;
        id_extra[4]   = 191; id_extra[5]   = 217; id_extra[6]   = 104; id_extra[7]   = 119;
        id_extra[9]   = 219; id_extra[10]  = 60;  id_extra[11]  = 186; id_extra[12]  = 10;
        id_extra[20]  = 89;  id_extra[21]  = 159; id_extra[22]  = 162; id_extra[23]  = 121;
        id_extra[25]  = 149; id_extra[26]  = 222; id_extra[27]  = 110; id_extra[28]  = 179;
        id_extra[29]  = 136; id_extra[30]  = 66;  id_extra[31]  = 126; id_extra[32]  = 185;
        id_extra[33]  = 147; id_extra[34]  = 112; id_extra[35]  = 252; id_extra[36]  = 162;
        id_extra[37]  = 215; id_extra[38]  = 229; id_extra[39]  = 128; id_extra[40]  = 9;
        id_extra[41]  = 106; id_extra[42]  = 101; id_extra[43]  = 213; id_extra[44]  = 4;
        id_extra[45]  = 229; id_extra[46]  = 21;  id_extra[47]  = 214; id_extra[48]  = 215;
        id_extra[49]  = 14;  id_extra[50]  = 206; id_extra[51]  = 50;  id_extra[52]  = 157;
        id_extra[53]  = 126; id_extra[54]  = 108; id_extra[55]  = 213; id_extra[56]  = 95;
        id_extra[57]  = 5;   id_extra[58]  = 127; id_extra[62]  = 57;  id_extra[63]  = 126;
        id_extra[64]  = 130; id_extra[65]  = 119; id_extra[66]  = 193; id_extra[67]  = 191;
        id_extra[68]  = 236; id_extra[69]  = 158; id_extra[70]  = 143; id_extra[73]  = 104;
        id_extra[74]  = 123; id_extra[75]  = 131; id_extra[76]  = 8;   id_extra[100] = 174;
        id_extra[140] = 155; id_extra[150] = 143; id_extra[151] = 29;  id_extra[152] = 208;
        id_extra[153] = 188; id_extra[154] = 118; id_extra[155] = 242; id_extra[156] = 19;
        id_extra[157] = 97;  id_extra[158] = 233; id_extra[251] = 178; id_extra[252] = 224;
        id_extra[253] = 60;  id_extra[254] = 106; id_extra[255] = 7;
    end

    // Bit-serial reflected CCITT step (poly 0x8408)
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
        return r;
    endfunction

    // Advance the frame state by one byte; return 1 when the byte closes a frame
    function automatic bit frame_step(input mfcrc_pkg::in_item_t it,
                                      output mfcrc_pkg::out_item_t res);
        logic [7:0] seed;
        res = '0;
        if (it.frame_start || frame_pos == 9'd0)
        begin
            frame_crc = mfcrc_pkg::CRC_INIT;
            frame_id  = 8'd0;
            frame_pos = 9'd1;
        end
        else
        begin
            frame_crc = crc_byte(frame_crc, it.data_byte);
            if (frame_pos == ID_POS)
                frame_id = it.data_byte;
            if (frame_pos < POS_LIMIT)
                frame_pos++;
        end
        if (!it.frame_end)
            return 1'b0;
        seed           = id_extra[frame_id];
        res.crc_value  = crc_byte(frame_crc, seed);
        res.extra_seed = seed;
        frame_crc      = mfcrc_pkg::CRC_INIT;
        frame_pos      = 9'd0;
        frame_id       = 8'd0;
        return 1'b1;
    endfunction

    task automatic push_byte(input mfcrc_pkg::in_item_t it, input bit typed,
                             input mfcrc_pkg::out_item_t want);
        mfcrc_pkg::out_item_t got;
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
        if (frame_step(it, got))
            crc_expect.push_back(typed ? want : got);
    endtask

    // Result side: check each transaction, then pick the next ready level
    initial
    begin
        mfcrc_pkg::out_item_t w;
        crc_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && crc_valid && crc_ready)
            begin
                if (crc_expect.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result crc_value=%h extra_seed=%h",
                             $time, crc_item.crc_value, crc_item.extra_seed);
                end
                else
                begin
                    w = crc_expect.pop_front();
                    checks_done++;
                    if (crc_item.crc_value !== w.crc_value)
                    begin
                        errors++;
                        $display("%0t: crc_value expected %h actual %h",
                                 $time, w.crc_value, crc_item.crc_value);
                    end
                    if (crc_item.extra_seed !== w.extra_seed)
                    begin
                        errors++;
                        $display("%0t: extra_seed expected %h actual %h",
                                 $time, w.extra_seed, crc_item.extra_seed);
                    end
                end
            end
            crc_ready <= rst_n && (calm || $urandom_range(0, 99) >= 26);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && byte_ready) || (crc_valid && crc_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("mavlink_frame_crc_unit verification failed");
        $finish;
    end

    initial
    begin
        mfcrc_pkg::in_item_t  it;
        mfcrc_pkg::out_item_t none;
        int                   kind;
        int                   plen;
        int                   nbytes;
        int                   frame_no;
        int                   long_frames;

        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        byte_item   = '0;
        calm        = 1'b0;
        errors      = 0;
        bytes_sent  = 0;
        checks_done = 0;
        frame_crc   = mfcrc_pkg::CRC_INIT;
        frame_pos   = 9'd0;
        frame_id    = 8'd0;
        none        = '0;
        frame_no    = 0;
        long_frames = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_byte(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        while (bytes_sent < DIR_ROWS + RANDOM_BYTES)
        begin
            // hold both sides busy through one long stretch
            calm = (bytes_sent >= 700 && bytes_sent < 1000);
            kind = $urandom_range(0, 99);
            // two long frames: one past the position saturation, one past 8 bits
            if (frame_no == 4 || frame_no == 20)
            begin
                kind = 0;
                plen = (frame_no == 4) ? $urandom_range(505, 530) : $urandom_range(256, 300);
                long_frames++;
            end
            else
                plen = $urandom_range(0, 32);

            if (kind < 78)
            begin
                nbytes = 6 + plen;
                for (int i = 0; i < nbytes; i++)
                begin
                    it = '0;
                    case (i)
                        0: it.data_byte = ($urandom_range(0, 3) != 0) ? SYNC_BYTE
                                                                       : 8'($urandom_range(0, 255));
                        1: it.data_byte = plen[7:0];
                        5: it.data_byte = $urandom_range(0, 1) ? 8'($urandom_range(0, 76))
                                                               : 8'($urandom_range(0, 255));
                        default: it.data_byte = 8'($urandom_range(0, 255));
                    endcase
                    it.frame_start = (i == 0);
                    it.frame_end   = (i == nbytes - 1);
                    push_byte(it, 1'b0, none);
                end
            end
            else if (kind < 90)
            begin
                // short frame, start flag sometimes missing
                nbytes = $urandom_range(1, 7);
                for (int i = 0; i < nbytes; i++)
                begin
                    it.data_byte   = 8'($urandom_range(0, 255));
                    it.frame_start = (i == 0) && $urandom_range(0, 1);
                    it.frame_end   = (i == nbytes - 1);
                    push_byte(it, 1'b0, none);
                end
            end
            else
            begin
                nbytes = $urandom_range(1, 10);
                for (int i = 0; i < nbytes; i++)
                begin
                    it.data_byte   = 8'($urandom_range(0, 255));
                    it.frame_start = ($urandom_range(0, 99) < 15);
                    it.frame_end   = ($urandom_range(0, 99) < 15);
                    push_byte(it, 1'b0, none);
                end
            end
            frame_no++;
        end
        calm = 1'b0;
        byte_valid <= 1'b0;

        while (crc_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d directed rows and %0d random frames (%0d long).",
                 bytes_sent, DIR_ROWS, frame_no, long_frames);
        $display("Compared %0d checksum results, %0d mismatches.", checks_done, errors);
        if (errors == 0)
            $display("mavlink_frame_crc_unit verification clean");
        else
            $display("mavlink_frame_crc_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
design/mfcrc_pkg.sv
design/mfcrc_front.sv
design/mfcrc_queue.sv
design/mfcrc_back.sv
design/mavlink_frame_crc_unit.sv
test/mavlink_frame_crc_unit_tb.sv
